/* hdl/ssp_pkg.sv */
// Shared types and constants for the stepper slot positioner.
package ssp_pkg;

    // Fixed field and state widths
    localparam int SLOT_W  = 3;
    localparam int CNT_W   = 10;
    localparam int TDATA_W = 8;

    // Step count saturation limits
    localparam logic signed [CNT_W-1:0] CNT_MAX = 10'sd511;
    localparam logic signed [CNT_W-1:0] CNT_MIN = -10'sd512;

    // One tick as it enters the tracker
    typedef struct packed {
        logic              goal_write;
        logic [SLOT_W-1:0] goal_slot;
        logic              limit_pressed;
    } tick_t;

    // One result as it leaves the tracker
    typedef struct packed {
        logic              step_pulse;
        logic              step_forward;
        logic [SLOT_W-1:0] slot_now;
        logic              is_aligned;
        logic              goal_active;
    } result_t;

endpackage

/* hdl/ssp_tracker.sv */
// Position state and single-pass next-state logic for one tick.
module ssp_tracker import ssp_pkg::*;
#(
    parameter int STEPS_PER_SLOT = 33,
    parameter int SLOTS          = 6
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  logic    reverse_direction,
    input  tick_t   tick,
    output result_t result
);

    localparam int RW    = (STEPS_PER_SLOT > 1) ? $clog2(STEPS_PER_SLOT) : 1;
    localparam int SUM_W = SLOT_W + 1;

    localparam logic [RW-1:0]     M_LAST    = RW'(STEPS_PER_SLOT - 1);
    localparam logic [RW-1:0]     M_HALF    = RW'(STEPS_PER_SLOT / 2 - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
    localparam logic [SUM_W-1:0]  SLOTS_S   = SUM_W'(SLOTS);
    localparam logic [SUM_W-1:0]  HALF_OFF  = SUM_W'(SLOTS / 2);

    // Step count, its residue modulo STEPS_PER_SLOT and floored quotient modulo SLOTS
    logic signed [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RW-1:0]           res_reg, res_next;
    logic [SLOT_W-1:0]       quo_reg, quo_next;
    logic                    half_reg, half_next;
    logic [SLOT_W-1:0]       cur_reg, cur_next;
    logic [SLOT_W-1:0]       tgt_reg, tgt_next;
    logic                    tv_reg, tv_next;
    logic                    fwd_last_reg, fwd_last_next;

    logic                    aligned;
    logic                    round_up;
    logic [SUM_W-1:0]        sum;
    logic [SLOT_W-1:0]       slot_calc;
    logic                    pulse;
    logic                    fwd;

    always_comb
    begin
        cnt_next      = cnt_reg;
        res_next      = res_reg;
        quo_next      = quo_reg;
        half_next     = half_reg;
        tgt_next      = tgt_reg;
        tv_next       = tv_reg;
        fwd_last_next = fwd_last_reg;
        pulse         = 1'b0;
        fwd           = 1'b0;

        // Goal load, out-of-range slots ignored
        if (tick.goal_write && ({1'b0, tick.goal_slot} < SLOTS_S))
        begin
            tgt_next = tick.goal_slot;
            tv_next  = 1'b1;
        end

        // Limit press: zero the count, maybe flip the half-turn flag
        if (tick.limit_pressed)
        begin
            if (fwd_last_reg != reverse_direction)
                half_next = ~half_reg;
            cnt_next = '0;
            res_next = '0;
            quo_next = '0;
        end

        // Slot recomputation near a boundary
        aligned  = (res_next <= RW'(1)) || (res_next >= M_LAST);
        round_up = (res_next > M_HALF);
        sum      = {1'b0, quo_next} + SUM_W'(round_up) + (half_next ? '0 : HALF_OFF);
        if (sum >= SLOTS_S)
            sum = sum - SLOTS_S;
        slot_calc = sum[SLOT_W-1:0];
        cur_next  = aligned ? slot_calc : cur_reg;

        // One step toward the goal, or retire the goal
        if (!tv_next || (cur_next == tgt_next))
        begin
            tv_next = 1'b0;
        end
        else
        begin
            pulse         = 1'b1;
            fwd           = (cur_next < tgt_next);
            fwd_last_next = fwd;
            if (fwd)
            begin
                if (cnt_next < CNT_MAX)
                begin
                    cnt_next = cnt_next + 10'sd1;
                    if (res_next == M_LAST)
                    begin
                        res_next = '0;
                        quo_next = (quo_next == SLOT_LAST) ? '0 : quo_next + SLOT_W'(1);
                    end
                    else
                    begin
                        res_next = res_next + RW'(1);
                    end
                end
            end
            else
            begin
                if (cnt_next > CNT_MIN)
                begin
                    cnt_next = cnt_next - 10'sd1;
                    if (res_next == '0)
                    begin
                        res_next = M_LAST;
                        quo_next = (quo_next == '0) ? SLOT_LAST : quo_next - SLOT_W'(1);
                    end
                    else
                    begin
                        res_next = res_next - RW'(1);
                    end
                end
            end
        end

        result.step_pulse   = pulse;
        result.step_forward = fwd;
        result.slot_now     = cur_next;
        result.is_aligned   = aligned;
        result.goal_active  = tv_next;
    end

    // State registers, updated once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            res_reg      <= '0;
            quo_reg      <= '0;
            half_reg     <= 1'b1;
            cur_reg      <= '0;
            tgt_reg      <= '0;
            tv_reg       <= 1'b0;
            fwd_last_reg <= 1'b1;
        end
        else if (advance)
        begin
            cnt_reg      <= cnt_next;
            res_reg      <= res_next;
            quo_reg      <= quo_next;
            half_reg     <= half_next;
            cur_reg      <= cur_next;
            tgt_reg      <= tgt_next;
            tv_reg       <= tv_next;
            fwd_last_reg <= fwd_last_next;
        end
    end

endmodule

/* hdl/stepper_slot_positioner_top.sv */
// Top level of the stepper slot positioner: stream ports, input and result registers.
//
// The block takes one tick transaction per clock cycle on the s_ side and returns
// exactly one result per tick on the m_ side, registered in the input register and
// then in the result register. Throughput is one tick per cycle while the output is
// not stalled: the step count is kept together with its residue modulo STEPS_PER_SLOT
// and its quotient modulo SLOTS, so the whole tick, from goal load to step issue, is
// computed combinationally between the input register and the result register.
// While the result register waits, the input register can still take one more tick;
// a longer output stall holds s_tready low until the waiting result is taken. The user
// must write reverse_direction on the cfg_ channel only while idle; it is not enforced.
module stepper_slot_positioner_top import ssp_pkg::*;
#(
    parameter int STEPS_PER_SLOT = 33,
    parameter int SLOTS          = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    // cfg_data: reverse_direction
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    // s_tdata: [0] goal_write, [3:1] goal_slot, [4] limit_pressed, [7:5] zero
    input  logic [TDATA_W-1:0] s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // m_tdata: [0] step_pulse, [1] step_forward, [4:2] slot_now, [5] is_aligned,
    //          [6] goal_active, [7] zero
    output logic [TDATA_W-1:0] m_tdata
);

    logic    rev_dir_reg;
    logic    in_valid_reg;
    tick_t   in_tick_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t res;
    logic    advance;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rev_dir_reg <= 1'b0;
        else if (cfg_valid)
            rev_dir_reg <= cfg_data;
    end

    // Handshake: a tick moves on when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_tick_reg.goal_write    <= s_tdata[0];
            in_tick_reg.goal_slot     <= s_tdata[3:1];
            in_tick_reg.limit_pressed <= s_tdata[4];
        end
    end

    ssp_tracker #(
        .STEPS_PER_SLOT (STEPS_PER_SLOT),
        .SLOTS          (SLOTS)
    ) u_tracker (
        .clk               (clk),
        .rst_n             (rst_n),
        .advance           (advance),
        .reverse_direction (rev_dir_reg),
        .tick              (in_tick_reg),
        .result            (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg.goal_active, out_res_reg.is_aligned,
                       out_res_reg.slot_now, out_res_reg.step_forward,
                       out_res_reg.step_pulse};

endmodule

/* hdl/ssp_checker.sv */
// Port-level checks for the stepper slot positioner, bound to the top level.
module ssp_checker import ssp_pkg::*;
#(
    parameter int SLOTS = 6
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    // No direction without a step
    a_fwd_needs_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> !m_tdata[1])
        else $error("step_forward set without step_pulse");

    // A pending goal after a tick means a step was issued in that tick, and a step means a pending goal
    a_pulse_goal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == m_tdata[6]))
        else $error("step_pulse and goal_active disagree");

    // Reported slot stays within the carousel
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[4:2]} < 4'(SLOTS)))
        else $error("slot_now out of range");

    // A draining output never blocks the input
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output is taken");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule

bind stepper_slot_positioner_top ssp_checker #(
    .SLOTS (SLOTS)
) u_ssp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
